@@ sv/rc4_pkg.sv @@
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types and constants for the RC4 stream cipher core.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int unsigned RC4_KEY_MAX    = 256;
  localparam int unsigned RC4_SBOX_DEPTH = 256;

  typedef logic [7:0] rc4_byte_t;

  localparam logic OPER_KEY  = 1'b0;
  localparam logic OPER_DATA = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_KEY_WR,
    OP_SCHED_INIT,
    OP_SCHED_RD,
    OP_SCHED_ACC,
    OP_SCHED_W1,
    OP_SCHED_W2,
    OP_DATA_START,
    OP_DATA_J,
    OP_DATA_W1,
    OP_DATA_W2,
    OP_DATA_OUT
  } rc4_op_e;

  typedef struct packed {
    logic sched_last;
  } rc4_status_t;

endpackage

@@ sv/rc4_if.sv @@
// ----------------------------------------------------------------------------
// rc4 channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface rc4_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] byte_in;
  logic       last_byte;

  modport source (output valid, output operation, output byte_in, output last_byte,
                  input ready);
  modport sink   (input valid, input operation, input byte_in, input last_byte,
                  output ready);
endinterface

interface rc4_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_byte;
  logic       message_end;

  modport source (output valid, output result_byte, output message_end, input ready);
  modport sink   (input valid, input result_byte, input message_end, output ready);
endinterface

@@ sv/rc4_ctrl.sv @@
// ----------------------------------------------------------------------------
// rc4_ctrl
// Sequencer for key loading, key schedule and keystream generation.
// ----------------------------------------------------------------------------
module rc4_ctrl
  import rc4_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_operation_i,
  input  logic        in_last_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  rc4_status_t status_i,
  output rc4_op_e     cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_RD,
    S_ACC,
    S_W1,
    S_W2,
    S_DJ,
    S_DW1,
    S_DW2,
    S_DOUT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   in_fire;
  logic   out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cmd_o = (in_operation_i == OPER_DATA) ? OP_DATA_START : OP_KEY_WR;
        end
      end
      S_INIT:  cmd_o = OP_SCHED_INIT;
      S_RD:    cmd_o = OP_SCHED_RD;
      S_ACC:   cmd_o = OP_SCHED_ACC;
      S_W1:    cmd_o = OP_SCHED_W1;
      S_W2:    cmd_o = OP_SCHED_W2;
      S_DJ:    cmd_o = OP_DATA_J;
      S_DW1:   cmd_o = OP_DATA_W1;
      S_DW2:   cmd_o = OP_DATA_W2;
      S_DOUT: begin
        if (out_free) begin
          cmd_o = OP_DATA_OUT;
        end
      end
      default: cmd_o = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_DOUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (in_operation_i == OPER_DATA) begin
              state_q <= S_DJ;
            end else if (in_last_i) begin
              state_q <= S_INIT;
            end
          end
        end
        S_INIT: state_q <= S_RD;
        S_RD:   state_q <= S_ACC;
        S_ACC:  state_q <= S_W1;
        S_W1:   state_q <= S_W2;
        S_W2:   state_q <= status_i.sched_last ? S_IDLE : S_RD;
        S_DJ:   state_q <= S_DW1;
        S_DW1:  state_q <= S_DW2;
        S_DW2:  state_q <= S_DOUT;
        S_DOUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/rc4_dpath.sv @@
// ----------------------------------------------------------------------------
// rc4_dpath
// Permutation table, key store, indices and output register.
// ----------------------------------------------------------------------------
module rc4_dpath
  import rc4_pkg::*;
#(
  parameter int unsigned KEY_MAX = RC4_KEY_MAX
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  rc4_op_e     cmd_i,
  output rc4_status_t status_o,
  input  rc4_byte_t   byte_i,
  input  logic        last_i,
  output rc4_byte_t   result_byte_o,
  output logic        message_end_o
);

  localparam int unsigned KIW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int unsigned KCW = $clog2(KEY_MAX + 1);
  localparam int unsigned SDW = $clog2(RC4_SBOX_DEPTH);

  rc4_byte_t s_mem [RC4_SBOX_DEPTH];
  rc4_byte_t k_mem [KEY_MAX];

  logic [RC4_SBOX_DEPTH-1:0] s_valid_q;
  logic [SDW-1:0]            s_raddr, s_raddr_q, s_waddr;
  rc4_byte_t                 s_rdata_q, s_wdata, s_rd;
  logic                      s_rvalid_q, s_we;
  rc4_byte_t                 k_rdata_q;

  rc4_byte_t      i_q, j_q, n_q;
  logic [KIW-1:0] kpos_q;
  logic [KCW-1:0] key_count_q;
  logic [KCW-1:0] kpos_inc;
  rc4_byte_t      si_q, sj_q, byte_q, result_byte_q;
  logic           last_q, fwd_q, message_end_q;
  rc4_byte_t      acc, jn, t_idx, ks;

  assign s_rd     = s_rvalid_q ? s_rdata_q : rc4_byte_t'(s_raddr_q);
  assign acc      = j_q + s_rd + k_rdata_q;
  assign jn       = j_q + s_rd;
  assign t_idx    = si_q + sj_q;
  assign ks       = fwd_q ? si_q : s_rd;
  assign kpos_inc = KCW'(kpos_q) + KCW'(1);

  assign status_o.sched_last = (n_q == 8'hFF);
  assign result_byte_o       = result_byte_q;
  assign message_end_o       = message_end_q;

  always_comb begin
    s_raddr = s_raddr_q;
    s_we    = 1'b0;
    s_waddr = i_q;
    s_wdata = s_rd;
    unique case (cmd_i)
      OP_SCHED_RD:   s_raddr = n_q;
      OP_SCHED_ACC:  s_raddr = acc;
      OP_SCHED_W1: begin
        s_we    = 1'b1;
        s_waddr = n_q;
        s_wdata = s_rd;
      end
      OP_SCHED_W2: begin
        s_we    = 1'b1;
        s_waddr = j_q;
        s_wdata = si_q;
      end
      OP_DATA_START: s_raddr = i_q + 8'd1;
      OP_DATA_J:     s_raddr = jn;
      OP_DATA_W1: begin
        s_we    = 1'b1;
        s_waddr = i_q;
        s_wdata = s_rd;
      end
      OP_DATA_W2: begin
        s_we    = 1'b1;
        s_waddr = j_q;
        s_wdata = si_q;
        s_raddr = t_idx;
      end
      default: begin
        s_raddr = s_raddr_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      s_mem[s_waddr] <= s_wdata;
    end
    s_rdata_q <= s_mem[s_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == OP_KEY_WR && key_count_q < KCW'(KEY_MAX)) begin
      k_mem[key_count_q[KIW-1:0]] <= byte_i;
    end
    k_rdata_q <= k_mem[kpos_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q   <= '0;
      s_raddr_q   <= '0;
      s_rvalid_q  <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      n_q         <= '0;
      kpos_q      <= '0;
      key_count_q <= '0;
    end else begin
      s_raddr_q  <= s_raddr;
      s_rvalid_q <= s_valid_q[s_raddr];
      if (cmd_i == OP_SCHED_INIT) begin
        s_valid_q <= '0;
      end else if (s_we) begin
        s_valid_q[s_waddr] <= 1'b1;
      end
      unique case (cmd_i)
        OP_KEY_WR: begin
          if (key_count_q < KCW'(KEY_MAX)) begin
            key_count_q <= key_count_q + KCW'(1);
          end
        end
        OP_SCHED_INIT: begin
          i_q    <= '0;
          j_q    <= '0;
          n_q    <= '0;
          kpos_q <= '0;
        end
        OP_SCHED_ACC: j_q <= acc;
        OP_SCHED_W2: begin
          n_q    <= n_q + 8'd1;
          kpos_q <= (kpos_inc >= key_count_q) ? '0 : kpos_inc[KIW-1:0];
          if (n_q == 8'hFF) begin
            j_q         <= '0;
            key_count_q <= '0;
          end
        end
        OP_DATA_START: i_q <= i_q + 8'd1;
        OP_DATA_J:     j_q <= jn;
        default: begin
          i_q <= i_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      OP_SCHED_ACC: si_q <= s_rd;
      OP_DATA_START: begin
        byte_q <= byte_i;
        last_q <= last_i;
      end
      OP_DATA_J:  si_q  <= s_rd;
      OP_DATA_W1: sj_q  <= s_rd;
      OP_DATA_W2: fwd_q <= (t_idx == j_q);
      OP_DATA_OUT: begin
        result_byte_q <= byte_q ^ ks;
        message_end_q <= last_q;
      end
      default: begin
        si_q <= si_q;
      end
    endcase
  end

endmodule

@@ sv/rc4_stream_cipher_core.sv @@
// ----------------------------------------------------------------------------
// rc4_stream_cipher_core
// RC4 keystream generator with key loading and key schedule.
// ----------------------------------------------------------------------------
// in_i carries one byte per transaction. operation = 0 stores a key byte
// (bytes beyond KEY_MAX are dropped); a key byte with last_byte set starts
// the key schedule on the bytes held so far. operation = 1 encrypts or
// decrypts byte_in and returns one transaction on out_o with message_end
// copied from last_byte.
// A key byte is stored when it is taken. The key schedule then runs 256 steps
// (read S[n], read S[j], two writes on the single table write port) after a
// set-up state, so the last key byte holds in_i off until the schedule ends.
// A data byte passes S_DJ, S_DW1 and S_DW2 to the result register in S_DOUT,
// and the next transaction is taken only after that: data bytes never overlap.
// A result waits in its output register while out_o is stalled; the next
// transaction on in_i is still taken, and a further data byte holds in its
// last step until the register is free.
// After reset the table reads as the identity permutation through per-entry
// valid bits, both indices are zero and no key is loaded.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_core
  import rc4_pkg::*;
#(
  parameter int unsigned KEY_MAX = RC4_KEY_MAX
) (
  input  logic clk_i,
  input  logic rst_ni,
  rc4_in_if.sink    in_i,
  rc4_out_if.source out_o
);

  rc4_op_e     cmd;
  rc4_status_t status;

  rc4_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_i.valid),
    .in_operation_i (in_i.operation),
    .in_last_i      (in_i.last_byte),
    .in_ready_o     (in_i.ready),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  rc4_dpath #(
    .KEY_MAX (KEY_MAX)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .byte_i        (in_i.byte_in),
    .last_i        (in_i.last_byte),
    .result_byte_o (out_o.result_byte),
    .message_end_o (out_o.message_end)
  );

endmodule
